>>> rtl/core/delimiter_segment_splitter_unit_macros.svh
// Assertion macros used by the checker file of the delimiter segment splitter.
// No dependencies; the file that includes it supplies clock and reset names.
`ifndef DELIMITER_SEGMENT_SPLITTER_UNIT_MACROS_SVH
`define DELIMITER_SEGMENT_SPLITTER_UNIT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define DSS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked around reset.
`define DSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/dss_pkg.sv
// Package of the delimiter segment splitter: beat types, register codes and sizes.
// No dependencies; every other file of the block but the assertion macro header uses it.
`timescale 1ns / 1ps

package dss_pkg;

   localparam int MAX_DELIM_BYTES = 8;
   localparam int OFFSET_BITS     = 16;
   localparam int LEN_BITS        = 4;
   localparam int CSR_DATA_BITS   = 64;
   localparam int CSR_ADDR_BITS   = 4;
   localparam int FIFO_DEPTH      = 4;
   localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);

   localparam logic [OFFSET_BITS-1:0]   OFS_MAX       = '1;
   localparam logic [CSR_DATA_BITS-1:0] PATTERN_RESET = 64'd44;
   localparam logic [LEN_BITS-1:0]      LENGTH_RESET  = 4'd1;

   // Register index, taken from the word address of the register port.
   localparam logic REG_PATTERN = 1'b0;
   localparam logic REG_LENGTH  = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_string;
   } dss_req_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] segment_start;
      logic [OFFSET_BITS-1:0] segment_length;
      logic                   final_segment;
      logic                   too_long;
   } dss_rsp_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] delim_pattern;
      logic [LEN_BITS-1:0]      delim_length;
   } dss_cfg_type;

   // Up to two result beats produced by one input byte.
   typedef struct packed {
      logic [1:0]  beats;
      dss_rsp_type first;
      dss_rsp_type second;
   } dss_batch_type;

endpackage

>>> rtl/core/dss_csr_regs.sv
// Register port of the delimiter segment splitter: delimiter pattern and length.
// Depends on dss_pkg.
`timescale 1ns / 1ps

module dss_csr_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dss_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [dss_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [dss_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready,
   output dss_pkg::dss_cfg_type                cfg
);

   logic [dss_pkg::CSR_DATA_BITS-1:0] pattern_ff, pattern_in;
   logic [dss_pkg::LEN_BITS-1:0]      length_ff, length_in;
   logic                              write_en;
   logic                              reg_sel;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[dss_pkg::CSR_ADDR_BITS-1];

   always_comb begin
      pattern_in = pattern_ff;
      length_in  = length_ff;
      csr_prdata = '0;
      case (reg_sel)
         dss_pkg::REG_PATTERN: begin
            csr_prdata = pattern_ff;
            if (write_en) begin
               pattern_in = csr_pwdata;
            end
         end
         dss_pkg::REG_LENGTH: begin
            csr_prdata = dss_pkg::CSR_DATA_BITS'(length_ff);
            if (write_en) begin
               length_in = csr_pwdata[dss_pkg::LEN_BITS-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= dss_pkg::PATTERN_RESET;
         length_ff  <= dss_pkg::LENGTH_RESET;
      end else begin
         pattern_ff <= pattern_in;
         length_ff  <= length_in;
      end
   end

   assign cfg.delim_pattern = pattern_ff;
   assign cfg.delim_length  = length_ff;

endmodule

>>> rtl/core/dss_split_core.sv
// Per-byte split logic: byte window, delimiter compare, segment offsets and string state.
// Depends on dss_pkg.
`timescale 1ns / 1ps

module dss_split_core #(
   parameter int MAX_DELIM_BYTES = dss_pkg::MAX_DELIM_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  dss_pkg::dss_req_type  req,
   input  dss_pkg::dss_cfg_type  cfg,
   output dss_pkg::dss_batch_type batch
);

   localparam int WB = 8 * MAX_DELIM_BYTES;
   localparam int OB = dss_pkg::OFFSET_BITS;
   localparam int LB = dss_pkg::LEN_BITS;

   logic [WB-1:0] window_ff, window_in, window_new, mask;
   logic [OB-1:0] pos_ff, pos_in, cur_ff, cur_in, cur_after, match_len, fin_len;
   logic [OB:0]   end_x, seg_end, fin_diff;
   logic [LB-1:0] len_eff;
   logic          ovf_ff, ovf_in, ovf_now, at_max, hit, last;

   always_comb begin
      // Out-of-range lengths fold into 1..MAX_DELIM_BYTES.
      len_eff = cfg.delim_length;
      if (cfg.delim_length == '0) begin
         len_eff = LB'(1);
      end else if (cfg.delim_length > LB'(MAX_DELIM_BYTES)) begin
         len_eff = LB'(MAX_DELIM_BYTES);
      end
      for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
         mask[8*i +: 8] = (LB'(i) < len_eff) ? 8'hFF : 8'h00;
      end

      last       = req.end_of_string;
      at_max     = (pos_ff == dss_pkg::OFS_MAX);
      ovf_now    = ovf_ff | at_max;
      window_new = (window_ff << 8) | WB'(req.data_byte);
      end_x      = (OB+1)'(pos_ff) + (OB+1)'(1);

      // A match counts only if it lies wholly inside the open segment.
      hit = (end_x >= ((OB+1)'(cur_ff) + (OB+1)'(len_eff))) &&
            (((window_new ^ cfg.delim_pattern[WB-1:0]) & mask) == '0);

      seg_end   = end_x - (OB+1)'(len_eff);
      match_len = OB'(seg_end - (OB+1)'(cur_ff));
      cur_after = cur_ff;
      if (hit) begin
         cur_after = end_x[OB] ? dss_pkg::OFS_MAX : end_x[OB-1:0];
      end

      fin_diff = end_x - (OB+1)'(cur_after);
      if (end_x < (OB+1)'(cur_after)) begin
         fin_len = '0;
      end else if (fin_diff[OB]) begin
         fin_len = dss_pkg::OFS_MAX;
      end else begin
         fin_len = fin_diff[OB-1:0];
      end

      batch.first.segment_start   = cur_ff;
      batch.first.segment_length  = match_len;
      batch.first.final_segment   = 1'b0;
      batch.first.too_long        = ovf_now;
      batch.second.segment_start  = cur_after;
      batch.second.segment_length = fin_len;
      batch.second.final_segment  = 1'b1;
      batch.second.too_long       = ovf_now;
      batch.beats                 = 2'd0;
      if (hit) begin
         batch.beats = last ? 2'd2 : 2'd1;
      end else if (last) begin
         batch.first = batch.second;
         batch.beats = 2'd1;
      end
      if (!accept) begin
         batch.beats = 2'd0;
      end

      window_in = window_ff;
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      ovf_in    = ovf_ff;
      if (accept) begin
         if (last) begin
            window_in = '0;
            pos_in    = '0;
            cur_in    = '0;
            ovf_in    = 1'b0;
         end else begin
            window_in = window_new;
            pos_in    = at_max ? pos_ff : pos_ff + OB'(1);
            cur_in    = cur_after;
            ovf_in    = ovf_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         pos_ff    <= '0;
         cur_ff    <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         window_ff <= window_in;
         pos_ff    <= pos_in;
         cur_ff    <= cur_in;
         ovf_ff    <= ovf_in;
      end
   end

endmodule

>>> rtl/core/dss_rsp_fifo.sv
// Result queue: takes zero, one or two beats per cycle and hands out one while the consumer is ready.
// Depends on dss_pkg.
`timescale 1ns / 1ps

module dss_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  dss_pkg::dss_batch_type batch,
   output logic                   room_for_two,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dss_pkg::dss_rsp_type   rsp_payload
);

   localparam int PB = dss_pkg::FIFO_PTR_BITS;
   localparam int CB = PB + 1;

   dss_pkg::dss_rsp_type entry_ff [dss_pkg::FIFO_DEPTH];
   logic [PB-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CB-1:0] count_ff, count_in;
   logic          pop;

   assign rsp_valid    = (count_ff != '0);
   assign rsp_payload  = entry_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= CB'(dss_pkg::FIFO_DEPTH - 2));
   assign pop          = rsp_valid & rsp_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PB'(batch.beats);
      rd_ptr_in = rd_ptr_ff + PB'(pop);
      count_in  = count_ff + CB'(batch.beats) - CB'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (batch.beats != 2'd0) begin
         entry_ff[wr_ptr_ff] <= batch.first;
      end
      if (batch.beats == 2'd2) begin
         entry_ff[wr_ptr_ff + PB'(1)] <= batch.second;
      end
   end

endmodule

>>> rtl/core/delimiter_segment_splitter_unit.sv
// Delimiter segment splitter, top level. Depends on dss_pkg, dss_csr_regs,
// dss_split_core and dss_rsp_fifo. An accepted byte's beats are written into the
// result queue, offered from its registers. Throughput: one byte per cycle, held
// back only when the four-entry queue lacks room for two beats. Reset is synchronous,
// active high, clears string state and the queue, and loads the default delimiter.
`timescale 1ns / 1ps

module delimiter_segment_splitter_unit #(
   parameter int MAX_DELIM_BYTES = dss_pkg::MAX_DELIM_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   // Byte input channel.
   input  logic                              req_valid,
   output logic                              req_ready,
   input  dss_pkg::dss_req_type              req_payload,
   // Segment result channel.
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output dss_pkg::dss_rsp_type              rsp_payload,
   // Register port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dss_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [dss_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [dss_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   // The delimiter pattern sits at byte address 0 and its length at byte address 8.
   // Both registers are 64-bit words; only the low four bits of the length are kept.

   dss_pkg::dss_cfg_type   cfg;
   dss_pkg::dss_batch_type batch;
   logic                   room_for_two;
   logic                   accept;

   // A byte may produce a segment for a delimiter match and the final segment
   // at once, so input beats are taken only while two queue entries are free.
   // The queue decouples the two channels: the next byte is accepted while
   // earlier results still wait for the consumer.
   assign req_ready = room_for_two;
   assign accept    = req_valid & req_ready;

   dss_csr_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The window compare and all offset arithmetic finish in the cycle the byte
   // is accepted; the resulting beats are written straight into the queue.
   dss_split_core #(
      .MAX_DELIM_BYTES (MAX_DELIM_BYTES)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .cfg    (cfg),
      .batch  (batch)
   );

   dss_rsp_fifo u_fifo (
      .clock        (clock),
      .reset        (reset),
      .batch        (batch),
      .room_for_two (room_for_two),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload)
   );

endmodule

>>> rtl/core/dss_checker.sv
// Port-level checks of the delimiter segment splitter and their bind to the top level.
// Depends on dss_pkg and delimiter_segment_splitter_unit_macros.svh.
`timescale 1ns / 1ps
`include "delimiter_segment_splitter_unit_macros.svh"

module dss_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input dss_pkg::dss_rsp_type rsp_payload
);

   `DSS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp beat dropped")
   `DSS_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_payload), "rsp beat changed")
   `DSS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && req_ready, "not empty after reset")
   `DSS_ASSERT(a_empty_ready, clock, reset, !rsp_valid |-> req_ready, "empty queue refuses bytes")

endmodule

bind delimiter_segment_splitter_unit dss_checker u_dss_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
